/* src/btr_pkg.sv */
// Package for the background tile row renderer: types, constants and helpers.
package btr_pkg;

    localparam int PATTERN_WORDS_DEF = 8192;
    localparam int PALETTE_ENTRIES   = 256;
    localparam int PAL_AW            = 8;
    localparam int ADDR_W            = 13;
    localparam int DATA_W            = 32;
    localparam int ATTR_W            = 16;
    localparam int ROW_W             = 4;
    localparam int POS_W             = 4;
    localparam int WRAP_STEPS        = 3;

    localparam logic [POS_W-1:0] LAST_PIX_16 = 4'd15;
    localparam logic [POS_W-1:0] LAST_PIX_8  = 4'd7;

    typedef enum logic [1:0] {
        OP_WR_PAT = 2'd0,
        OP_WR_PAL = 2'd1,
        OP_RENDER = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             pat_wr;
        logic             pal_wr;
        logic             pat_rd0;
        logic             pat_rd1;
        logic             pal_rd;
        logic             tile_is_16;
        logic [POS_W-1:0] pix;
        logic             last;
    } t_cmd;

    // Brings a word address into range by repeated subtraction of the memory depth.
    function automatic logic [ADDR_W-1:0] wrap_words(input logic [ADDR_W-1:0] addr,
                                                     input logic [ADDR_W:0]   words);
        logic [ADDR_W-1:0] r;
        r = addr;
        for (int s = 0; s < WRAP_STEPS; s++) begin
            if ({1'b0, r} >= words) begin
                r = r - words[ADDR_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

/* src/btr_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module btr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/btr_ctrl.sv */
// Controller: transaction decode, row sequencing, pixel counter and output valid.
module btr_ctrl
    import btr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_op,
    input  logic             i_out_stall,
    input  logic             i_cfg_valid,
    input  logic             i_tile_is_16,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output logic             o_cfg_ready,
    output t_cmd             o_cmd
);

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pix, n_pix;
    logic             r_out_valid, n_out_valid;
    logic             r_tile_is_16;
    logic             in_acc;
    logic             slot_free;
    logic             pal_rd;
    logic             last;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign last      = (r_pix == (r_tile_is_16 ? LAST_PIX_16 : LAST_PIX_8));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_op == OP_RENDER)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free && last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.pat_wr  = 1'b0;
        o_cmd.pal_wr  = 1'b0;
        o_cmd.pat_rd0 = 1'b0;
        o_cmd.pat_rd1 = 1'b0;
        pal_rd        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.pat_wr  = i_in_valid && (i_op == OP_WR_PAT);
                o_cmd.pal_wr  = i_in_valid && (i_op == OP_WR_PAL);
                o_cmd.pat_rd0 = i_in_valid && (i_op == OP_RENDER);
            end
            ST_FETCH: begin
                o_cmd.pat_rd1 = 1'b1;
            end
            ST_EMIT: begin
                pal_rd = slot_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        o_cmd.pal_rd     = pal_rd;
        o_cmd.tile_is_16 = r_tile_is_16;
        o_cmd.pix        = r_pix;
        o_cmd.last       = last;
    end

    always_comb begin
        n_pix = r_pix;
        if (pal_rd) begin
            n_pix = last ? '0 : r_pix + 4'd1;
        end
        n_out_valid = r_out_valid;
        if (pal_rd) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pix        <= '0;
            r_out_valid  <= 1'b0;
            r_tile_is_16 <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_pix       <= n_pix;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_tile_is_16 <= i_tile_is_16;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

endmodule

/* src/btr_dp.sv */
// Datapath: pattern and palette memories, word addressing, nibble select and result fields.
module btr_dp
    import btr_pkg::*;
#(
    parameter int PATTERN_WORDS = PATTERN_WORDS_DEF
) (
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [ADDR_W-1:0] i_mem_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [ATTR_W-1:0] i_tile_attr,
    input  logic [ROW_W-1:0]  i_tile_row,
    output logic [DATA_W-1:0] o_pixel_color,
    output logic [POS_W-1:0]  o_pixel_pos,
    output logic              o_row_last
);

    localparam int                PAT_AW  = $clog2(PATTERN_WORDS);
    localparam logic [ADDR_W:0]   WORDS_W = (ADDR_W+1)'(PATTERN_WORDS);

    logic [7:0]        r_pat;
    logic [3:0]        r_bank;
    logic              r_hflip;
    logic [ROW_W-1:0]  r_y;
    logic [DATA_W-1:0] r_word;
    logic [POS_W-1:0]  r_pos;
    logic              r_last;

    logic [ROW_W-1:0]  y16;
    logic [2:0]        y8;
    logic [ADDR_W-1:0] addr0_raw;
    logic [ADDR_W-1:0] addr1_raw;
    logic [ADDR_W-1:0] pat_raddr_full;
    logic [ADDR_W-1:0] pat_waddr_full;
    logic [DATA_W-1:0] pat_rdata;
    logic [POS_W-1:0]  q;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] swapped;
    logic [3:0]        nib;
    logic [PAL_AW-1:0] pal_raddr;

    assign y16 = i_tile_attr[15] ? ~i_tile_row : i_tile_row;
    assign y8  = i_tile_attr[15] ? ~i_tile_row[2:0] : i_tile_row[2:0];

    assign addr0_raw = i_cmd.tile_is_16 ? {i_tile_attr[7:0], 1'b0, y16}
                                        : {2'b00, i_tile_attr[7:0], y8};
    assign addr1_raw = {r_pat, 1'b1, r_y};

    assign pat_raddr_full = wrap_words(i_cmd.pat_rd0 ? addr0_raw : addr1_raw, WORDS_W);
    assign pat_waddr_full = wrap_words(i_mem_address, WORDS_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.pat_rd0) begin
            r_pat   <= i_tile_attr[7:0];
            r_bank  <= i_tile_attr[11:8];
            r_hflip <= i_tile_attr[14];
            r_y     <= y16;
        end
        if (i_cmd.pat_rd1) begin
            r_word <= pat_rdata;
        end
        if (i_cmd.pal_rd) begin
            r_pos  <= i_cmd.pix;
            r_last <= i_cmd.last;
        end
    end

    btr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PATTERN_WORDS)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pat_wr),
        .i_waddr (pat_waddr_full[PAT_AW-1:0]),
        .i_wdata (i_write_data),
        .i_re    (i_cmd.pat_rd0 || i_cmd.pat_rd1),
        .i_raddr (pat_raddr_full[PAT_AW-1:0]),
        .o_rdata (pat_rdata)
    );

    // Screen position maps to a source nibble; the second word is still held in the RAM output.
    assign q       = r_hflip ? ~i_cmd.pix : i_cmd.pix;
    assign word    = (i_cmd.tile_is_16 && q[3]) ? pat_rdata : r_word;
    assign swapped = {word[15:0], word[31:16]};
    assign nib     = swapped[{~q[2:0], 2'b00} +: 4];
    assign pal_raddr = {r_bank, nib};

    btr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pal_wr),
        .i_waddr (i_mem_address[PAL_AW-1:0]),
        .i_wdata (i_write_data),
        .i_re    (i_cmd.pal_rd),
        .i_raddr (pal_raddr),
        .o_rdata (o_pixel_color)
    );

    assign o_pixel_pos = r_pos;
    assign o_row_last  = r_last;

endmodule

/* src/bg_tile_row_render_top.sv */
// Top level of the background tile row renderer.
//
//  Channel   Direction  Handshake                Payload
//  in        input      i_in_valid / o_in_stall   op, mem_address, write_data, tile_attr, tile_row
//  out       output     o_out_valid / i_out_stall pixel_color, pixel_pos, row_last
//  cfg       input      i_cfg_valid / o_cfg_ready tile_is_16
//
// A write transaction leaves the controller idle. A render transaction issues two
// pattern reads and then emits one pixel per cycle while the output is not stalled,
// a rate set by the single palette read port. Reset is synchronous and leaves both
// memories unwritten; no clearing pass runs. A stall on the output holds the pixel
// in flight and pauses the row; the next input is taken once the last palette read
// of the row has been issued.
module bg_tile_row_render_top
    import btr_pkg::*;
#(
    parameter int PATTERN_WORDS = PATTERN_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_mem_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [ATTR_W-1:0] i_tile_attr,
    input  logic [ROW_W-1:0]  i_tile_row,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DATA_W-1:0] o_pixel_color,
    output logic [POS_W-1:0]  o_pixel_pos,
    output logic              o_row_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_tile_is_16
);

    t_cmd cmd;

    btr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_op         (i_op),
        .i_out_stall  (i_out_stall),
        .i_cfg_valid  (i_cfg_valid),
        .i_tile_is_16 (i_tile_is_16),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_cfg_ready  (o_cfg_ready),
        .o_cmd        (cmd)
    );

    btr_dp #(
        .PATTERN_WORDS (PATTERN_WORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_mem_address (i_mem_address),
        .i_write_data  (i_write_data),
        .i_tile_attr   (i_tile_attr),
        .i_tile_row    (i_tile_row),
        .o_pixel_color (o_pixel_color),
        .o_pixel_pos   (o_pixel_pos),
        .o_row_last    (o_row_last)
    );

endmodule

/* src/btr_chk.sv */
// Port-level checker for the background tile row renderer, bound to the top level.
module btr_chk
    import btr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [1:0]        i_op,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DATA_W-1:0] o_pixel_color,
    input logic [POS_W-1:0]  o_pixel_pos,
    input logic              o_row_last
);

    a_render_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_op == OP_RENDER)) |=> o_in_stall)
        else $error("Input not stalled after a render transaction.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_pixel_color) && $stable(o_pixel_pos)
             && $stable(o_row_last)))
        else $error("Stalled pixel changed.");

    a_row_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_row_last) |=>
            (o_out_valid && (o_pixel_pos == POS_W'($past(o_pixel_pos) + 4'd1))))
        else $error("Pixel row broken or out of order.");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_row_last) |->
            ((o_pixel_pos == LAST_PIX_8) || (o_pixel_pos == LAST_PIX_16)))
        else $error("Row end flagged at a wrong position.");

endmodule

bind bg_tile_row_render_top btr_chk u_btr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_op          (i_op),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_pixel_color (o_pixel_color),
    .o_pixel_pos   (o_pixel_pos),
    .o_row_last    (o_row_last)
);

/* tb/btr_pixel_compare.sv */
`timescale 1ns / 100ps
// Pixel predictor and comparator for the background tile row renderer testbench.
module btr_pixel_compare
    import btr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_mem_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [ATTR_W-1:0] i_tile_attr,
    input  logic [ROW_W-1:0]  i_tile_row,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [DATA_W-1:0] i_pixel_color,
    input  logic [POS_W-1:0]  i_pixel_pos,
    input  logic              i_row_last,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_tile_is_16,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] color;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_pixel;

    t_pixel            pixels_due [$];
    logic [DATA_W-1:0] pattern_copy [0:PATTERN_WORDS_DEF-1];
    logic [DATA_W-1:0] palette_copy [0:PALETTE_ENTRIES-1];
    logic              tile16_mode = 1'b1;
    int                mismatches = 0;

    // The pattern word is half-swapped and its nibbles are used from the top down.
    function automatic logic [DATA_W-1:0] nibble_color(input logic [DATA_W-1:0] word,
                                                       input logic [3:0] bank,
                                                       input int k);
        logic [DATA_W-1:0] swapped;
        swapped = {word[15:0], word[31:16]};
        return palette_copy[{bank, swapped[31-4*k -: 4]}];
    endfunction

    function automatic void predict_row(input logic [ATTR_W-1:0] attr,
                                        input logic [ROW_W-1:0] row);
        logic [DATA_W-1:0] row_colors [0:15];
        logic [DATA_W-1:0] left_word;
        logic [DATA_W-1:0] right_word;
        logic [3:0]        y;
        int                n;
        t_pixel            pix;
        if (tile16_mode) begin
            y = row ^ {4{attr[15]}};
            left_word  = pattern_copy[{attr[7:0], 1'b0, y}];
            right_word = pattern_copy[{attr[7:0], 1'b1, y}];
            for (int k = 0; k < 8; k++) begin
                if (attr[14]) begin
                    row_colors[15-k] = nibble_color(left_word, attr[11:8], k);
                    row_colors[7-k]  = nibble_color(right_word, attr[11:8], k);
                end else begin
                    row_colors[k]   = nibble_color(left_word, attr[11:8], k);
                    row_colors[8+k] = nibble_color(right_word, attr[11:8], k);
                end
            end
            n = 16;
        end else begin
            left_word = pattern_copy[{2'b00, attr[7:0], row[2:0] ^ {3{attr[15]}}}];
            for (int k = 0; k < 8; k++) begin
                row_colors[attr[14] ? 7-k : k] = nibble_color(left_word, attr[11:8], k);
            end
            n = 8;
        end
        for (int i = 0; i < n; i++) begin
            pix.color = row_colors[i];
            pix.pos   = POS_W'(i);
            pix.last  = (i == n - 1);
            pixels_due.push_back(pix);
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            tile16_mode = 1'b1;
            pixels_due.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pixels_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected pixel: color %h pos %0d last %0b",
                                 i_pixel_color, i_pixel_pos, i_row_last);
                    end
                end else begin
                    want = pixels_due.pop_front();
                    if (want.color !== i_pixel_color || want.pos !== i_pixel_pos ||
                        want.last !== i_row_last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("pixel mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                     want.color, want.pos, want.last,
                                     i_pixel_color, i_pixel_pos, i_row_last);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                tile16_mode = i_tile_is_16;
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_op)
                    OP_WR_PAT: pattern_copy[i_mem_address] = i_write_data;
                    OP_WR_PAL: palette_copy[i_mem_address[PAL_AW-1:0]] = i_write_data;
                    OP_RENDER: predict_row(i_tile_attr, i_tile_row);
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pixels_due.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the background tile row renderer: clock, reset, stimulus and verdict.
module tb_top;
    import btr_pkg::*;

    localparam logic [1:0] OP_NONE       = 2'd3;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         QUIET_LIMIT   = 3000;
    localparam int         HOLD_CYCLES   = 160;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic [1:0]        i_op          = OP_WR_PAT;
    logic [ADDR_W-1:0] i_mem_address = '0;
    logic [DATA_W-1:0] i_write_data  = '0;
    logic [ATTR_W-1:0] i_tile_attr   = '0;
    logic [ROW_W-1:0]  i_tile_row    = '0;
    logic              i_out_stall   = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              i_tile_is_16  = 1'b1;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [DATA_W-1:0] o_pixel_color;
    logic [POS_W-1:0]  o_pixel_pos;
    logic              o_row_last;
    logic              o_cfg_ready;

    int                fail_count;
    int                pending;

    logic [DATA_W-1:0] stim_pattern [0:PATTERN_WORDS_DEF-1];
    bit                pat_written [0:PATTERN_WORDS_DEF-1];
    bit                pal_written [0:PALETTE_ENTRIES-1];
    logic [7:0]        recent_tiles [0:7];
    logic              cur_mode     = 1'b1;
    bit                nibble_limit = 1'b0;
    bit                calm         = 1'b0;
    bit                hold_req     = 1'b0;
    bit                hold_done    = 1'b0;
    int                item_count   = 0;

    wire in_acc  = i_in_valid && !o_in_stall;
    wire out_acc = o_out_valid && !i_out_stall;
    wire cfg_acc = i_cfg_valid && o_cfg_ready;

    bg_tile_row_render_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_mem_address (i_mem_address),
        .i_write_data  (i_write_data),
        .i_tile_attr   (i_tile_attr),
        .i_tile_row    (i_tile_row),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_color (o_pixel_color),
        .o_pixel_pos   (o_pixel_pos),
        .o_row_last    (o_row_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_tile_is_16  (i_tile_is_16)
    );

    btr_pixel_compare u_pixel_compare (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_mem_address (i_mem_address),
        .i_write_data  (i_write_data),
        .i_tile_attr   (i_tile_attr),
        .i_tile_row    (i_tile_row),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_pixel_color (o_pixel_color),
        .i_pixel_pos   (o_pixel_pos),
        .i_row_last    (o_row_last),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_tile_is_16  (i_tile_is_16),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // In the directed part each nibble is either 0 or F, so few palette entries are needed.
    function automatic logic [DATA_W-1:0] pattern_data();
        logic [7:0]        sel;
        logic [DATA_W-1:0] word;
        sel  = 8'($urandom_range(0, 255));
        word = $urandom;
        if (nibble_limit) begin
            for (int k = 0; k < 8; k++) begin
                word[4*k +: 4] = {4{sel[k]}};
            end
        end
        return word;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic [ATTR_W-1:0] attr,
                             input logic [ROW_W-1:0] row);
        while (!calm && $urandom_range(0, 99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_mem_address <= addr;
        i_write_data  <= data;
        i_tile_attr   <= attr;
        i_tile_row    <= row;
        do @(posedge i_clk); while (o_in_stall);
        if (op == OP_WR_PAT) begin
            stim_pattern[addr] = data;
            pat_written[addr]  = 1'b1;
        end
        if (op == OP_WR_PAL) begin
            pal_written[addr[PAL_AW-1:0]] = 1'b1;
        end
        if (op != OP_NONE) begin
            item_count++;
        end
    endtask

    // Writes any unwritten pattern words and palette entries the row reads, then renders it.
    task automatic render_tile(input logic [ATTR_W-1:0] attr, input logic [ROW_W-1:0] row);
        logic [ADDR_W-1:0] words [0:1];
        int                nwords;
        logic [3:0]        y;
        logic [7:0]        idx;
        logic [4:0]        upper;
        if (cur_mode) begin
            y        = row ^ {4{attr[15]}};
            words[0] = {attr[7:0], 1'b0, y};
            words[1] = {attr[7:0], 1'b1, y};
            nwords   = 2;
        end else begin
            words[0] = {2'b00, attr[7:0], row[2:0] ^ {3{attr[15]}}};
            words[1] = words[0];
            nwords   = 1;
        end
        for (int j = 0; j < nwords; j++) begin
            if (!pat_written[words[j]] || $urandom_range(0, 7) == 0) begin
                send_item(OP_WR_PAT, words[j], pattern_data(),
                          ATTR_W'($urandom), ROW_W'($urandom));
            end
        end
        for (int j = 0; j < nwords; j++) begin
            for (int k = 0; k < 8; k++) begin
                idx   = {attr[11:8], stim_pattern[words[j]][4*k +: 4]};
                upper = 5'($urandom_range(0, 31));
                if (!pal_written[idx]) begin
                    send_item(OP_WR_PAL, {upper, idx}, $urandom,
                              ATTR_W'($urandom), ROW_W'($urandom));
                end
            end
        end
        send_item(OP_RENDER, ADDR_W'($urandom), $urandom, attr, row);
    endtask

    task automatic random_render();
        logic [7:0] tile;
        logic [3:0] bank;
        logic [3:0] flags;
        if ($urandom_range(0, 1) == 0) begin
            tile = recent_tiles[$urandom_range(0, 7)];
        end else begin
            tile = 8'($urandom_range(0, 255));
        end
        recent_tiles[$urandom_range(0, 7)] = tile;
        if ($urandom_range(0, 3) == 0) begin
            bank = 4'($urandom_range(0, 15));
        end else begin
            bank = 4'(4 * $urandom_range(0, 3));
        end
        flags = 4'($urandom_range(0, 15));
        render_tile({flags, bank, tile}, ROW_W'($urandom_range(0, 15)));
    endtask

    task automatic run_random(input int count);
        int                goal;
        int                roll;
        logic [ADDR_W-1:0] addr;
        goal = item_count + count;
        while (item_count < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                random_render();
            end else if (roll < 82) begin
                addr = ADDR_W'($urandom_range(0, PATTERN_WORDS_DEF - 1));
                if ($urandom_range(0, 1) == 0) begin
                    addr[12:5] = recent_tiles[$urandom_range(0, 7)];
                end
                send_item(OP_WR_PAT, addr, pattern_data(),
                          ATTR_W'($urandom), ROW_W'($urandom));
            end else if (roll < 94) begin
                send_item(OP_WR_PAL, ADDR_W'($urandom), $urandom,
                          ATTR_W'($urandom), ROW_W'($urandom));
            end else begin
                send_item(OP_NONE, ADDR_W'($urandom), $urandom,
                          ATTR_W'($urandom), ROW_W'($urandom));
            end
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_tile_mode(input logic mode);
        settle();
        i_cfg_valid  <= 1'b1;
        i_tile_is_16 <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 29);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_acc || out_acc || cfg_acc) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        for (int k = 0; k < 8; k++) begin
            recent_tiles[k] = 8'(k * 37);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        nibble_limit = 1'b1;
        set_tile_mode(1'b1);
        send_item(OP_WR_PAL, 13'h1F00, 32'h0000_0000, 16'hFFFF, 4'hF);
        send_item(OP_WR_PAL, 13'h000F, 32'hFFFF_FFFF, 16'h0000, 4'h0);
        send_item(OP_WR_PAL, 13'h0AF0, 32'h1234_5678, 16'hA5A5, 4'h5);
        send_item(OP_WR_PAL, 13'h1FFF, 32'hEDCB_A987, 16'h5A5A, 4'hA);
        render_tile(16'h0000, 4'd0);
        render_tile(16'h4FFF, 4'd15);
        render_tile(16'h8000, 4'd0);
        render_tile(16'hFFFF, 4'd8);
        send_item(OP_NONE, 13'h1FFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
        set_tile_mode(1'b0);
        render_tile(16'h0000, 4'd0);
        render_tile(16'h8FFF, 4'd15);
        render_tile(16'h7001, 4'd9);
        nibble_limit = 1'b0;

        run_random(40);
        set_tile_mode(1'b1);
        hold_req = 1'b1;
        run_random(45);
        calm = 1'b1;
        run_random(35);
        calm = 1'b0;
        set_tile_mode(1'b0);
        run_random(40);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
src/btr_pkg.sv
src/btr_ram.sv
src/btr_ctrl.sv
src/btr_dp.sv
src/bg_tile_row_render_top.sv
src/btr_chk.sv
tb/btr_pixel_compare.sv
tb/tb_top.sv
